FILE: hdl/ole_pkg.sv
// Shared types and constants for the ordered list engine.
package ole_pkg;

    localparam int unsigned DEPTH_DEF      = 16;
    localparam int unsigned ITEM_WIDTH_DEF = 32;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        MD_PUSH   = 2'd0,
        MD_POP    = 2'd1,
        MD_FIND   = 2'd2,
        MD_DELETE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]         mode;
        logic [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]   position;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] front_value;
        logic               found;
        logic [POS_W-1:0]   found_index;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
    } t_rsp;

endpackage

FILE: hdl/ordered_list_engine_top.sv
// Ordered list engine: bounded list held in a circular buffer with one sequencer.
//
// The list sits in a single-port-write, single-port-read memory used as a
// circular buffer, with position 0 at the head pointer. A request is taken
// only while the sequencer is idle; its result goes to an output register,
// so the next request may be taken while that result still waits. Push and
// rejected requests go straight to the result; pop moves the head on and
// rereads the new front unless the list empties; find reads and compares
// entries up to the first match; delete moves each later entry down one
// place and rereads the front, or only drops the count for the last entry.
// The memory has one write and one read port with registered read data, so
// each entry moved or compared takes a read state and a use state. The
// memory needs no clearing after reset.
module ordered_list_engine_top
    import ole_pkg::*;
#(
    parameter int unsigned DEPTH      = DEPTH_DEF,
    parameter int unsigned ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_rsp
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned VW = (ITEM_WIDTH < VALUE_W) ? ITEM_WIDTH : VALUE_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EXEC = 9'b000000010,
        S_FRD  = 9'b000000100,
        S_FCMP = 9'b000001000,
        S_DRD  = 9'b000010000,
        S_DWR  = 9'b000100000,
        S_HRD  = 9'b001000000,
        S_HCAP = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [ITEM_WIDTH-1:0] r_mem [DEPTH];
    logic [ITEM_WIDTH-1:0] r_rd_data;

    t_state                r_state, n_state;
    t_mode                 r_mode, n_mode;
    logic [ITEM_WIDTH-1:0] r_val, n_val;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_idx, n_idx;
    logic [ITEM_WIDTH-1:0] r_front, n_front;
    logic [ITEM_WIDTH-1:0] r_pop_front, n_pop_front;
    t_status               r_status, n_status;
    logic                  r_found, n_found;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_rsp, n_rsp;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [ITEM_WIDTH-1:0] w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [CW-1:0]         w_idx_p1;
    logic [CW-1:0]         w_idx_p2;
    logic [AW-1:0]         w_head_m1;
    logic [ITEM_WIDTH-1:0] w_front_sel;

    assign w_idx_p1  = r_idx + CW'(1);
    assign w_idx_p2  = r_idx + CW'(2);
    assign w_head_m1 = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_val       = r_val;
        n_pos       = r_pos;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_front     = r_front;
        n_pop_front = r_pop_front;
        n_status    = r_status;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_rsp       = r_rsp;
        w_we        = 1'b0;
        w_waddr     = r_head;
        w_wdata     = r_val;
        w_raddr     = r_head;
        w_front_sel = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = t_mode'(i_req.mode);
                    n_val    = ITEM_WIDTH'(i_req.item_value[VW-1:0]);
                    n_pos    = i_req.position;
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_idx    = '0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_mode)
                    MD_PUSH: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = w_head_m1;
                            n_head  = w_head_m1;
                            n_count = r_count + CW'(1);
                            n_front = r_val;
                        end
                        n_state = S_DONE;
                    end
                    MD_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_pop_front = r_front;
                            n_head      = wrap_add(r_head, AW'(1));
                            n_count     = r_count - CW'(1);
                            n_state     = (r_count == CW'(1)) ? S_DONE : S_HRD;
                        end
                    end
                    MD_FIND: begin
                        n_state = (r_count == '0) ? S_DONE : S_FRD;
                    end
                    MD_DELETE: begin
                        if (32'(r_pos) >= 32'(r_count)) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else if (32'(r_pos) + 32'd1 == 32'(r_count)) begin
                            // last entry goes: nothing to move
                            n_count = r_count - CW'(1);
                            n_state = S_DONE;
                        end else begin
                            n_idx   = CW'(r_pos);
                            n_state = S_DRD;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_FRD: begin
                w_raddr = wrap_add(r_head, r_idx[AW-1:0]);
                n_state = S_FCMP;
            end
            S_FCMP: begin
                if (r_rd_data == r_val) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (w_idx_p1 == r_count) begin
                    n_idx   = '0;
                    n_state = S_DONE;
                end else begin
                    n_idx   = w_idx_p1;
                    n_state = S_FRD;
                end
            end
            S_DRD: begin
                w_raddr = wrap_add(r_head, w_idx_p1[AW-1:0]);
                n_state = S_DWR;
            end
            S_DWR: begin
                // move the successor down one place
                w_we    = 1'b1;
                w_waddr = wrap_add(r_head, r_idx[AW-1:0]);
                w_wdata = r_rd_data;
                if (w_idx_p2 == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_HRD;
                end else begin
                    n_idx   = w_idx_p1;
                    n_state = S_DRD;
                end
            end
            S_HRD: begin
                w_raddr = r_head;
                n_state = S_HCAP;
            end
            S_HCAP: begin
                n_front = r_rd_data;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    if (r_mode == MD_POP && r_status == ST_OK) begin
                        w_front_sel = r_pop_front;
                    end else if (r_count != '0) begin
                        w_front_sel = r_front;
                    end
                    n_rsp.status      = r_status;
                    n_rsp.front_value = VALUE_W'(w_front_sel[VW-1:0]);
                    n_rsp.found       = r_found;
                    n_rsp.found_index = r_found ? POS_W'(r_idx) : '0;
                    n_rsp.entry_count = COUNT_W'(r_count);
                    n_rsp.is_empty    = (r_count == '0);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_val       <= n_val;
        r_pos       <= n_pos;
        r_idx       <= n_idx;
        r_front     <= n_front;
        r_pop_front <= n_pop_front;
        r_status    <= n_status;
        r_found     <= n_found;
        r_rsp       <= n_rsp;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule

FILE: hdl/ole_checker.sv
// Port-level checks for the ordered list engine, bound to the top level.
module ole_checker
    import ole_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_rsp o_rsp
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rsp))
        else $error("result dropped or changed while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after a request transfer");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_rsp.is_empty == (o_rsp.entry_count == '0))
        else $error("empty flag disagrees with entry count");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rsp.found |-> o_rsp.status == ST_OK)
        else $error("found set on a rejected request");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_rsp.found |-> o_rsp.found_index == '0)
        else $error("found index nonzero without a match");

endmodule

bind ordered_list_engine_top ole_checker u_ole_checker (.*);

FILE: test/list_scoreboard_pkg.sv
// Scoreboard class for the ordered list engine: list predictor and result checks.
package list_scoreboard_pkg;

    import ole_pkg::*;

    class list_scoreboard;

        logic [VALUE_W-1:0] entries [DEPTH_DEF];
        int unsigned        n_entries;
        t_rsp               expected_rsp [$];
        int unsigned        n_errors;

        function new();
            n_entries = 0;
            n_errors  = 0;
            foreach (entries[i]) entries[i] = '0;
        endfunction

        function int unsigned entry_count();
            return n_entries;
        endfunction

        function logic [VALUE_W-1:0] entry_at(int unsigned idx);
            return entries[idx];
        endfunction

        function int unsigned outstanding();
            return expected_rsp.size();
        endfunction

        function int unsigned error_count();
            return n_errors;
        endfunction

        function logic [VALUE_W-1:0] front_or_zero();
            return (n_entries > 0) ? entries[0] : '0;
        endfunction

        // Apply one accepted request to the list and queue the result it must give.
        function void note_request(t_req req);
            t_rsp want;
            int   i;
            want = '0;
            case (t_mode'(req.mode))
                MD_PUSH: begin
                    if (n_entries >= DEPTH_DEF) begin
                        want.status = ST_FULL;
                    end else begin
                        for (i = n_entries; i > 0; i--) entries[i] = entries[i-1];
                        entries[0] = req.item_value;
                        n_entries++;
                    end
                    want.front_value = front_or_zero();
                end
                MD_POP: begin
                    if (n_entries == 0) begin
                        want.status = ST_EMPTY;
                    end else begin
                        want.front_value = entries[0];
                        for (i = 0; i + 1 < n_entries; i++) entries[i] = entries[i+1];
                        n_entries--;
                    end
                end
                MD_FIND: begin
                    for (i = 0; i < n_entries; i++) begin
                        if (entries[i] == req.item_value) begin
                            want.found       = 1'b1;
                            want.found_index = i[POS_W-1:0];
                            break;
                        end
                    end
                    want.front_value = front_or_zero();
                end
                default: begin
                    if (req.position >= n_entries) begin
                        want.status = ST_RANGE;
                    end else begin
                        for (i = req.position; i + 1 < n_entries; i++) entries[i] = entries[i+1];
                        n_entries--;
                    end
                    want.front_value = front_or_zero();
                end
            endcase
            want.entry_count = n_entries[COUNT_W-1:0];
            want.is_empty    = (n_entries == 0);
            expected_rsp.push_back(want);
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_rsp.size() == 0) begin
                $error("result with nothing expected: %h", got);
                n_errors++;
                return;
            end
            want = expected_rsp.pop_front();
            compare_field("status", VALUE_W'(want.status), VALUE_W'(got.status));
            compare_field("front_value", want.front_value, got.front_value);
            compare_field("found", VALUE_W'(want.found), VALUE_W'(got.found));
            compare_field("found_index", VALUE_W'(want.found_index),
                          VALUE_W'(got.found_index));
            compare_field("entry_count", VALUE_W'(want.entry_count),
                          VALUE_W'(got.entry_count));
            compare_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(got.is_empty));
        endfunction

    endclass

endpackage

FILE: test/testbench.sv
// Testbench for the ordered list engine: directed and random requests with handshake stalls.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ole_pkg::*;
    import list_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_req i_req       = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_rsp o_rsp;

    list_scoreboard     sb;
    logic [VALUE_W-1:0] value_pool [8];
    int                 next_gap     = 0;
    int                 tx_quiet     = 0;
    int                 rx_quiet     = 0;
    int                 hold_pending = 0;

    ordered_list_engine_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req       (i_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Zero waits come in runs so that back-to-back stretches occur.
    function automatic int pick_wait(inout int quiet_run);
        if (quiet_run > 0) begin
            quiet_run--;
            return 0;
        end
        if ($urandom_range(15) == 0) begin
            quiet_run = $urandom_range(40, 8);
            return 0;
        end
        return $urandom_range(18);
    endfunction

    function automatic t_req make_req(t_mode m, logic [VALUE_W-1:0] v, logic [POS_W-1:0] p);
        t_req r;
        r.mode       = m;
        r.item_value = v;
        r.position   = p;
        return r;
    endfunction

    function automatic t_req random_request(input bit growing);
        t_req        r;
        int unsigned cnt;
        int unsigned roll;
        cnt  = sb.entry_count();
        roll = $urandom_range(99);
        r.item_value = ($urandom_range(3) == 0) ? value_pool[$urandom_range(7)]
                                                : VALUE_W'($urandom);
        r.position   = POS_W'($urandom_range(15));
        if (roll < 5) begin
            r.mode = 2'($urandom_range(3));
        end else if (roll < (growing ? 60 : 25)) begin
            r.mode = MD_PUSH;
        end else if (roll < (growing ? 72 : 60)) begin
            r.mode = MD_POP;
        end else if (roll < 86) begin
            r.mode = MD_FIND;
            if (cnt > 0 && $urandom_range(1) == 1)
                r.item_value = sb.entry_at($urandom_range(cnt - 1));
        end else begin
            r.mode = MD_DELETE;
            if (cnt > 0 && $urandom_range(7) != 0)
                r.position = POS_W'($urandom_range(cnt - 1));
        end
        return r;
    endfunction

    // Offer one request and hold it until the transfer; drop valid only if a gap follows.
    task automatic send_request(input t_req r);
        repeat (next_gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_req      <= r;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(r);
        next_gap = pick_wait(tx_quiet);
        if (next_gap > 0) i_in_valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        if (next_gap == 0) i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    initial begin : result_sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_pending > 0) begin
                stall        = hold_pending;
                hold_pending = 0;
            end else begin
                stall = pick_wait(rx_quiet);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_response(o_rsp);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial begin : stimulus
        bit                 growing;
        int unsigned        cnt;
        logic [VALUE_W-1:0] v;
        sb = new();
        value_pool[0] = '0;
        value_pool[1] = '1;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h0000_0001;
        for (int k = 4; k < 8; k++) value_pool[k] = VALUE_W'($urandom);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: rejected pop and deletes, find with nothing to match.
        send_request(make_req(MD_POP, '1, '0));
        send_request(make_req(MD_DELETE, '0, 4'd15));
        send_request(make_req(MD_DELETE, '0, 4'd0));
        send_request(make_req(MD_FIND, '0, '0));
        // Fill to the brim with a duplicate inside, then push once more.
        for (int k = 0; k < DEPTH_DEF; k++) begin
            if (k == 0)                v = '0;
            else if (k == DEPTH_DEF-1) v = '1;
            else if (k == 5 || k == 10) v = 32'hA5A5_A5A5;
            else                       v = 32'h0F0F_0000 | k;
            send_request(make_req(MD_PUSH, v, '1));
        end
        send_request(make_req(MD_PUSH, 32'h5A5A_5A5A, '0));
        send_request(make_req(MD_FIND, '0, '0));
        send_request(make_req(MD_FIND, 32'hA5A5_A5A5, '0));
        send_request(make_req(MD_FIND, 32'h1234_5678, '0));
        send_request(make_req(MD_DELETE, '0, 4'd15));
        send_request(make_req(MD_DELETE, '0, 4'd15));
        send_request(make_req(MD_DELETE, '0, 4'd0));
        send_request(make_req(MD_POP, '0, '0));
        wait_for_drain();

        growing = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 600) hold_pending = HOLD_CYCLES;
            if (n == 350 || n == 1100 || n == 1700) wait_for_drain();
            cnt = sb.entry_count();
            if (cnt == DEPTH_DEF && $urandom_range(3) == 0)
                growing = 1'b0;
            else if (cnt == 0 && $urandom_range(3) == 0)
                growing = 1'b1;
            else if ($urandom_range(199) == 0)
                growing = !growing;
            send_request(random_request(growing));
        end

        wait_for_drain();
        repeat (60) @(posedge i_clk);
        if (sb.error_count() == 0 && sb.outstanding() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
hdl/ole_pkg.sv
hdl/ordered_list_engine_top.sv
hdl/ole_checker.sv
test/list_scoreboard_pkg.sv
test/testbench.sv
